@@ rtl/dcfb_pkg.sv @@
// ============================================================================
// DCF backoff package
// Shared types, event codes and default widths for the contention block.
// ============================================================================
package dcfb_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int CW_BITS_DEF   = 10;
    localparam int OP_BITS       = 3;
    localparam int PARAM_BITS    = 16;

    typedef enum logic [1:0] {
        FSM_IDLE    = 2'd0,
        FSM_DEFER   = 2'd1,
        FSM_BACKOFF = 2'd2
    } t_fsm;

    typedef enum logic [OP_BITS-1:0] {
        OP_START   = 3'd0,
        OP_MEDIUM  = 3'd1,
        OP_CORRUPT = 3'd2,
        OP_TICK    = 3'd3,
        OP_CANCEL  = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_EXEC,
        SQ_MOD,
        SQ_MUL,
        SQ_SUM,
        SQ_DMIN,
        SQ_SCHED,
        SQ_KEEP,
        SQ_OUT
    } t_seq;

endpackage

@@ rtl/dcfb_div.sv @@
// ============================================================================
// DCF backoff divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ============================================================================
module dcfb_div #(
    parameter int N = 48,
    parameter int M = 17
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [M-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quot,
    output logic [M-1:0] o_rem
);
    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [N-1:0]     r_quot;
    logic [M-1:0]     r_rem;
    logic [M-1:0]     r_div;
    logic [M:0]       shifted;
    logic [M:0]       trial;

    assign shifted = {r_rem, r_quot[N-1]};
    assign trial   = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (!trial[M]) begin
                r_rem  <= trial[M-1:0];
                r_quot <= {r_quot[N-2:0], 1'b1};
            end else begin
                r_rem  <= shifted[M-1:0];
                r_quot <= {r_quot[N-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

@@ rtl/dcf_backoff_contention.sv @@
// ============================================================================
// DCF backoff contention
// Channel contention machine with idle, defer and ifs-plus-backoff states.
// ============================================================================
// Each input item is one event: the kind travels on s_tuser, the start
// parameters and the new medium state on s_tdata. Each accepted item yields
// exactly one result item on the m_ side with the state after the event,
// grant and schedule report flags, the scheduled tick, held slots and an
// error flag. i_cfg_we writes the option that lets a start's wait shrink by
// the time since the last medium event or grant. One item is handled at a
// time. Tick, cancel and simple events pass from the decode state straight
// to the result. A start from idle runs the shared restoring divider for the
// modulo one bit per cycle; with the medium free the shift-add multiplier
// then forms slots times slot length one bit per cycle, and the sum, minimum
// and schedule steps follow. A busy medium during backoff runs the divider
// for the ceiling divide. A free medium while deferring or a corrupted frame
// during backoff replans without the divider. With a ready receiver the
// result is taken as soon as it appears, and the block passes through idle
// before it takes the next item. s_tready is high only while no event is in
// progress. The result is held in registers until the receiver takes it; a
// stalled receiver stalls the input side as well. Reset sets the state to
// idle with the medium free and the tick clock at a quarter of its range; it
// takes effect at the first rising edge with i_rst_n low.
module dcf_backoff_contention #(
    parameter int TIME_BITS = dcfb_pkg::TIME_BITS_DEF,
    parameter int CW_BITS   = dcfb_pkg::CW_BITS_DEF,
    parameter int IN_W      = ((CW_BITS + 65 + 7) / 8) * 8,
    parameter int OUT_W     = ((TIME_BITS + CW_BITS + 6 + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // opcode
    input  logic [dcfb_pkg::OP_BITS-1:0] s_tuser,
    // contention_window, ifs_ticks, eifs_ticks, slot_ticks, random_draw,
    // medium_is_free, zero pad
    input  logic [IN_W-1:0]              s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // fsm_state, access_granted, expect_report, expect_withdrawn,
    // expect_time, slots_left, event_error, zero pad
    output logic [OUT_W-1:0]             m_tdata,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata
);
    import dcfb_pkg::*;

    localparam int PW     = PARAM_BITS;
    localparam int PROD_W = CW_BITS + PW;
    localparam int WAIT_W = PROD_W + 1;
    localparam int XW     = (WAIT_W > TIME_BITS) ? WAIT_W : TIME_BITS;
    localparam int DIVR_W = PW + 1;
    localparam int MC_W   = $clog2(CW_BITS + 1);
    localparam int PAD_O  = OUT_W - (TIME_BITS + CW_BITS + 6);

    t_seq r_seq, n_seq;

    // Configuration and contention state.
    logic                 r_opt;
    t_fsm                 r_fsm;
    logic                 r_free;
    logic [TIME_BITS-1:0] r_now;
    logic [PW-1:0]        r_ifs, r_eifs, r_slot;
    logic [CW_BITS-1:0]   r_slots;
    logic [TIME_BITS-1:0] r_sched, r_eifs_end, r_last_busy, r_last_idle;
    logic                 r_live;

    // Latched event.
    t_op                  r_op;
    logic [CW_BITS-1:0]   r_cw;
    logic [PW-1:0]        r_in_ifs, r_in_eifs, r_in_slot, r_draw;
    logic                 r_in_free;

    // Result flags.
    logic                 r_granted, r_rep, r_wd, r_err;
    logic [TIME_BITS-1:0] r_etime;

    // Planning datapath.
    logic                 r_plan_opt;
    logic [PROD_W-1:0]    r_acc, r_mcand;
    logic [CW_BITS-1:0]   r_mplier;
    logic [MC_W-1:0]      r_mcnt;
    logic [WAIT_W-1:0]    r_wait;
    logic [TIME_BITS-1:0] r_dmin;

    // Divider hookup.
    logic                 div_start, div_done;
    logic [TIME_BITS-1:0] div_dividend, div_quot;
    logic [DIVR_W-1:0]    div_divisor, div_rem;

    logic [TIME_BITS-1:0] ifs_end, d_busy, d_idle, sched_new;
    logic [XW-1:0]        wx, dx, wfin;
    logic [TIME_BITS:0]   ceil_q;
    logic                 use_eifs;
    logic [PW-1:0]        base;

    assign s_tready = (r_seq == SQ_IDLE);
    assign m_tvalid = (r_seq == SQ_OUT);
    assign m_tdata  = {{PAD_O{1'b0}}, r_err, r_slots, r_etime, r_wd, r_rep,
                       r_granted, r_fsm};

    // The divider serves the modulo of a start and the ceiling divide of a
    // busy medium during backoff; both are launched from the decode cycle.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = TIME_BITS'(r_draw);
        div_divisor  = DIVR_W'(r_cw) + DIVR_W'(1);
        if (r_seq == SQ_EXEC) begin
            if (r_op == OP_START && r_fsm == FSM_IDLE) begin
                div_start = 1'b1;
            end else if (r_op == OP_MEDIUM && r_fsm == FSM_BACKOFF && !r_in_free) begin
                div_start    = 1'b1;
                div_dividend = r_sched - r_now;
                div_divisor  = DIVR_W'(r_slot);
            end
        end
    end

    dcfb_div #(
        .N (TIME_BITS),
        .M (DIVR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // EIFS applies when its end lies beyond now plus IFS.
    assign ifs_end   = r_now + TIME_BITS'(r_ifs);
    assign use_eifs  = r_eifs_end > ifs_end;
    assign base      = use_eifs ? r_eifs : r_ifs;
    assign d_busy    = r_now - r_last_busy;
    assign d_idle    = r_now - r_last_idle;
    assign wx        = XW'(r_wait);
    assign dx        = XW'(r_dmin);
    assign wfin      = (r_plan_opt && r_opt) ? (wx - ((wx < dx) ? wx : dx)) : wx;
    assign sched_new = r_now + wfin[TIME_BITS-1:0];
    assign ceil_q    = {1'b0, div_quot} + (TIME_BITS + 1)'(div_rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SQ_IDLE: begin
                if (s_tvalid) n_seq = SQ_EXEC;
            end
            SQ_EXEC: begin
                n_seq = SQ_OUT;
                case (r_op)
                    OP_START: begin
                        if (r_fsm == FSM_IDLE) n_seq = SQ_MOD;
                    end
                    OP_MEDIUM: begin
                        if (r_fsm == FSM_DEFER && r_in_free) n_seq = SQ_MUL;
                        if (r_fsm == FSM_BACKOFF && !r_in_free) n_seq = SQ_KEEP;
                    end
                    OP_CORRUPT: begin
                        if (r_fsm == FSM_BACKOFF) n_seq = SQ_MUL;
                    end
                    default: n_seq = SQ_OUT;
                endcase
            end
            SQ_MOD: begin
                if (div_done) n_seq = r_free ? SQ_MUL : SQ_OUT;
            end
            SQ_MUL: begin
                if (r_mcnt == MC_W'(1)) n_seq = SQ_SUM;
            end
            SQ_SUM:   n_seq = SQ_DMIN;
            SQ_DMIN:  n_seq = SQ_SCHED;
            SQ_SCHED: n_seq = SQ_OUT;
            SQ_KEEP: begin
                if (div_done) n_seq = SQ_OUT;
            end
            SQ_OUT: begin
                if (m_tready) n_seq = SQ_IDLE;
            end
            default: n_seq = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt       <= 1'b0;
            r_fsm       <= FSM_IDLE;
            r_free      <= 1'b1;
            r_now       <= TIME_BITS'(1) << (TIME_BITS - 2);
            r_ifs       <= '0;
            r_eifs      <= '0;
            r_slot      <= PW'(1);
            r_slots     <= '0;
            r_sched     <= '0;
            r_eifs_end  <= '0;
            r_last_busy <= '0;
            r_last_idle <= '0;
            r_live      <= 1'b0;
        end else begin
            if (i_cfg_we) r_opt <= i_cfg_wdata;
            case (r_seq)
                SQ_EXEC: begin
                    case (r_op)
                        OP_START: begin
                            if (r_fsm == FSM_IDLE) begin
                                r_ifs  <= r_in_ifs;
                                r_eifs <= r_in_eifs;
                                r_slot <= (r_in_slot == '0) ? PW'(1) : r_in_slot;
                                r_live <= 1'b1;
                            end
                        end
                        OP_MEDIUM: begin
                            r_free      <= r_in_free;
                            r_last_busy <= r_now;
                            if (r_fsm == FSM_BACKOFF && !r_in_free) r_fsm <= FSM_DEFER;
                        end
                        OP_CORRUPT: begin
                            if (r_fsm != FSM_IDLE) r_eifs_end <= r_now + TIME_BITS'(r_eifs);
                        end
                        OP_TICK: begin
                            if (r_fsm == FSM_BACKOFF && r_now == r_sched) begin
                                r_fsm       <= FSM_IDLE;
                                r_last_idle <= r_now;
                                r_live      <= 1'b0;
                            end
                            r_now <= r_now + TIME_BITS'(1);
                        end
                        OP_CANCEL: begin
                            r_fsm  <= FSM_IDLE;
                            r_live <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                SQ_MOD: begin
                    if (div_done) begin
                        r_slots <= div_rem[CW_BITS-1:0];
                        if (!r_free) r_fsm <= FSM_DEFER;
                    end
                end
                SQ_SCHED: begin
                    r_sched <= sched_new;
                    r_fsm   <= FSM_BACKOFF;
                end
                SQ_KEEP: begin
                    if (div_done && ceil_q < (TIME_BITS + 1)'(r_slots)) begin
                        r_slots <= ceil_q[CW_BITS-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Event latch, result flags and the planning datapath.
    always_ff @(posedge i_clk) begin
        if (r_seq == SQ_IDLE && s_tvalid) begin
            r_op      <= t_op'(s_tuser);
            r_cw      <= s_tdata[CW_BITS-1:0];
            r_in_ifs  <= s_tdata[CW_BITS+15:CW_BITS];
            r_in_eifs <= s_tdata[CW_BITS+31:CW_BITS+16];
            r_in_slot <= s_tdata[CW_BITS+47:CW_BITS+32];
            r_draw    <= s_tdata[CW_BITS+63:CW_BITS+48];
            r_in_free <= s_tdata[CW_BITS+64];
        end
        case (r_seq)
            SQ_EXEC: begin
                r_granted  <= 1'b0;
                r_rep      <= 1'b0;
                r_wd       <= 1'b0;
                r_err      <= 1'b0;
                r_etime    <= '0;
                r_plan_opt <= (r_op == OP_START);
                r_acc      <= '0;
                r_mcand    <= PROD_W'(r_slot);
                r_mplier   <= r_slots;
                r_mcnt     <= MC_W'(CW_BITS);
                case (r_op)
                    OP_START:   r_err <= (r_fsm != FSM_IDLE);
                    OP_MEDIUM: begin
                        if (r_fsm == FSM_DEFER && !r_in_free) r_err <= 1'b1;
                        if (r_fsm == FSM_BACKOFF) begin
                            r_err <= r_in_free;
                            r_rep <= !r_in_free;
                            r_wd  <= !r_in_free;
                        end
                    end
                    OP_CORRUPT: ;
                    OP_TICK: r_granted <= (r_fsm == FSM_BACKOFF && r_now == r_sched);
                    OP_CANCEL: begin
                        r_rep <= r_live;
                        r_wd  <= r_live;
                    end
                    default: r_err <= 1'b1;
                endcase
            end
            SQ_MOD: begin
                // The slot length is latched by now; reload the multiplier.
                r_mcand  <= PROD_W'(r_slot);
                r_mplier <= div_rem[CW_BITS-1:0];
            end
            SQ_MUL: begin
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_mcnt   <= r_mcnt - MC_W'(1);
            end
            SQ_SUM:  r_wait <= WAIT_W'(base) + WAIT_W'(r_acc);
            SQ_DMIN: r_dmin <= (d_busy < d_idle) ? d_busy : d_idle;
            SQ_SCHED: begin
                r_rep   <= 1'b1;
                r_etime <= sched_new;
            end
            default: ;
        endcase
    end
endmodule

@@ rtl/dcfb_check.sv @@
// ============================================================================
// DCF backoff port checker
// Concurrent checks on the ports of the contention block, bound to the top.
// ============================================================================
module dcfb_check #(
    parameter int TIME_BITS = 48,
    parameter int CW_BITS   = 10,
    parameter int OUT_W     = 64
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic [OUT_W-1:0] m_tdata
);
    import dcfb_pkg::*;

    localparam int ERR_BIT = TIME_BITS + CW_BITS + 5;

    // An event in progress holds off the next one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an event is in progress");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && m_tvalid))
        else $error("ready while a result waits");

    a_grant_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1:0] == FSM_IDLE && !m_tdata[ERR_BIT])
        else $error("grant without return to idle or with error");

    a_withdraw_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3] && m_tdata[TIME_BITS+4:5] == '0)
        else $error("withdrawal without report or with a time");
endmodule

bind dcf_backoff_contention dcfb_check #(
    .TIME_BITS (TIME_BITS),
    .CW_BITS   (CW_BITS),
    .OUT_W     (OUT_W)
) u_dcfb_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
);
